// ----- sv/ira_pkg.sv -----
// shared types, constants and helpers for the radix ascii formatter
package ira_pkg;

  localparam int ValueW     = 64;
  localparam int MinDigitsW = 6;
  localparam int CharW      = 8;
  localparam int LenW       = 7;
  localparam int RadixW     = 6;
  localparam int FlagsW     = 4;
  localparam int CfgIdxW    = 4;
  localparam int CfgDataW   = 8;

  localparam int OutputLimit     = 64;
  localparam int DigitStoreDepth = 64;
  localparam int DigitW          = 6;
  localparam int AddrW           = $clog2(DigitStoreDepth);
  localparam int QueueDepth      = 2;

  localparam logic [RadixW-1:0] RadixMin = 6'd2;
  localparam logic [RadixW-1:0] RadixMax = 6'd36;
  localparam logic [RadixW-1:0] RadixHex = 6'd16;
  localparam logic [RadixW-1:0] RadixOct = 6'd8;

  localparam int FlagPlus  = 0;
  localparam int FlagSpace = 1;
  localparam int FlagAlt   = 2;
  localparam int FlagUpper = 3;

  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChPlus   = 8'h2B;
  localparam logic [CharW-1:0] ChMinus  = 8'h2D;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChLowerA = 8'h61;
  localparam logic [CharW-1:0] ChUpperX = 8'h58;
  localparam logic [CharW-1:0] ChLowerX = 8'h78;
  localparam logic [CharW-1:0] ChNul    = 8'h00;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RADIX = 4'd0,
    CFG_FLAGS = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic                  bad;
    logic                  has_sign;
    logic [CharW-1:0]      sign_char;
    logic [1:0]            pfx_cnt;
    logic                  upper;
    logic [RadixW-1:0]     radix;
    logic [MinDigitsW-1:0] min_digits;
    logic [ValueW-1:0]     mag;
  } job_t;

  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d,
                                                  input logic upper);
    logic [CharW-1:0] base;
    base = upper ? ChUpperA : ChLowerA;
    if (d < DigitW'(10)) begin
      return ChZero + CharW'(d);
    end
    return base + CharW'(d) - CharW'(10);
  endfunction

endpackage

// ----- sv/ira_if.sv -----
// channel interfaces: input words, output words and register writes
interface ira_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [ira_pkg::ValueW-1:0] value;
  logic [ira_pkg::MinDigitsW-1:0]   min_digits;
  modport source (output valid, value, min_digits, input ready);
  modport sink (input valid, value, min_digits, output ready);
endinterface

interface ira_out_if;
  logic                        valid;
  logic                        ready;
  logic [ira_pkg::CharW-1:0]   character;
  logic                        last;
  logic                        truncated;
  logic [ira_pkg::LenW-1:0]    total_length;
  logic                        bad_radix;
  modport source (output valid, character, last, truncated, total_length, bad_radix,
                  input ready);
  modport sink (input valid, character, last, truncated, total_length, bad_radix,
                output ready);
endinterface

interface ira_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ira_pkg::CfgIdxW-1:0]  index;
  logic [ira_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/ira_front.sv -----
// front end: register file, input acceptance and per-word classification
module ira_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  ira_in_if.sink        in_i,
  ira_cfg_if.sink       cfg_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output ira_pkg::job_t push_job_o
);

  logic [ira_pkg::RadixW-1:0] radix_q;
  logic [ira_pkg::FlagsW-1:0] flags_q;
  logic                       neg;
  logic [ira_pkg::ValueW-1:0] mag;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= 6'd10;
      flags_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ira_pkg::CFG_RADIX: radix_q <= cfg_i.data[ira_pkg::RadixW-1:0];
        ira_pkg::CFG_FLAGS: flags_q <= cfg_i.data[ira_pkg::FlagsW-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  always_comb begin
    neg = in_i.value[ira_pkg::ValueW-1];
    mag = neg ? (~$unsigned(in_i.value) + 64'd1) : $unsigned(in_i.value);

    push_job_o.bad        = (radix_q < ira_pkg::RadixMin) || (radix_q > ira_pkg::RadixMax);
    push_job_o.upper      = flags_q[ira_pkg::FlagUpper];
    push_job_o.radix      = radix_q;
    push_job_o.min_digits = in_i.min_digits;
    push_job_o.mag        = mag;

    priority if (flags_q[ira_pkg::FlagPlus] && !neg) begin
      push_job_o.has_sign  = 1'b1;
      push_job_o.sign_char = ira_pkg::ChPlus;
    end else if (flags_q[ira_pkg::FlagSpace] && !neg) begin
      push_job_o.has_sign  = 1'b1;
      push_job_o.sign_char = ira_pkg::ChSpace;
    end else if (neg) begin
      push_job_o.has_sign  = 1'b1;
      push_job_o.sign_char = ira_pkg::ChMinus;
    end else begin
      push_job_o.has_sign  = 1'b0;
      push_job_o.sign_char = ira_pkg::ChNul;
    end

    priority if (flags_q[ira_pkg::FlagAlt] && radix_q == ira_pkg::RadixHex) begin
      push_job_o.pfx_cnt = 2'd2;
    end else if (flags_q[ira_pkg::FlagAlt] && radix_q == ira_pkg::RadixOct && mag != '0) begin
      push_job_o.pfx_cnt = 2'd1;
    end else begin
      push_job_o.pfx_cnt = 2'd0;
    end
  end

endmodule

// ----- sv/ira_fifo.sv -----
// short job queue between front and back
module ira_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ira_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ira_pkg::job_t pop_job_o
);

  localparam int PtrW = $clog2(ira_pkg::QueueDepth);
  localparam int CntW = $clog2(ira_pkg::QueueDepth + 1);

  ira_pkg::job_t   mem_q [ira_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push;
  logic            pop;

  assign push_ready_o = (cnt_q != CntW'(ira_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(ira_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(ira_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/ira_back.sv -----
// back end: digit extraction by iterated division, digit store and character output
module ira_back #(
  parameter int OUTPUT_LIMIT = ira_pkg::OutputLimit
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  ira_pkg::job_t pop_job_i,
  ira_out_if.source     out_o
);

  localparam int BitsPerCycle = 8;
  localparam int StepsPerDigit = ira_pkg::ValueW / BitsPerCycle;
  localparam int StepW = $clog2(StepsPerDigit);
  localparam int LenW = ira_pkg::LenW;
  localparam int AddrW = ira_pkg::AddrW;
  localparam logic [LenW-1:0] Limit = LenW'(OUTPUT_LIMIT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LEN,
    ST_EMIT,
    ST_ERR
  } state_e;

  state_e                      state_q;
  ira_pkg::job_t               job_q;
  logic [ira_pkg::ValueW-1:0]  dq_q;
  logic [ira_pkg::DigitW-1:0]  rem_q;
  logic [StepW-1:0]            step_q;
  logic [LenW-1:0]             count_q;
  logic [AddrW-1:0]            dp_q;
  logic [AddrW-1:0]            dp_d;
  logic [LenW-1:0]             k_q;
  logic [LenW-1:0]             b1_q;
  logic [LenW-1:0]             b2_q;
  logic [LenW-1:0]             b3_q;
  logic [LenW-1:0]             len_q;
  logic [LenW-1:0]             emit_q;
  logic [ira_pkg::DigitW-1:0]  rd_q;
  logic [ira_pkg::DigitW-1:0]  store_q [ira_pkg::DigitStoreDepth];

  logic                        ovalid_q;
  logic [ira_pkg::CharW-1:0]   ochar_q;
  logic                        olast_q;
  logic                        otrunc_q;
  logic [LenW-1:0]             olen_q;
  logic                        obad_q;

  logic [ira_pkg::ValueW-1:0]  quo_c;
  logic [ira_pkg::DigitW-1:0]  rem_c;
  logic [ira_pkg::DigitW:0]    trial;
  logic                        wr_en;
  logic [LenW-1:0]             mind_w;
  logic [LenW-1:0]             pad;
  logic [LenW-1:0]             b1_d;
  logic [LenW-1:0]             b2_d;
  logic [LenW-1:0]             b3_d;
  logic [LenW-1:0]             len_d;
  logic                        out_free;
  logic                        load_out;
  logic                        in_digits;
  logic                        fin;
  logic [ira_pkg::CharW-1:0]   char_c;

  // restoring division, several quotient bits per cycle
  always_comb begin
    quo_c = dq_q;
    rem_c = rem_q;
    trial = '0;
    for (int i = 0; i < BitsPerCycle; i++) begin
      trial = {rem_c, quo_c[ira_pkg::ValueW-1]};
      if (trial >= {1'b0, job_q.radix}) begin
        rem_c = ira_pkg::DigitW'(trial - {1'b0, job_q.radix});
        quo_c = {quo_c[ira_pkg::ValueW-2:0], 1'b1};
      end else begin
        rem_c = trial[ira_pkg::DigitW-1:0];
        quo_c = {quo_c[ira_pkg::ValueW-2:0], 1'b0};
      end
    end
  end

  assign wr_en = (state_q == ST_DIV) && (step_q == StepW'(StepsPerDigit - 1));

  always_comb begin
    mind_w = {1'b0, job_q.min_digits};
    pad    = (mind_w > count_q) ? mind_w - count_q : '0;
    b1_d   = LenW'(job_q.has_sign);
    b2_d   = b1_d + LenW'(job_q.pfx_cnt);
    b3_d   = b2_d + pad;
    len_d  = b3_d + count_q;
  end

  assign out_free  = !ovalid_q || out_o.ready;
  assign load_out  = out_free && ((state_q == ST_EMIT) || (state_q == ST_ERR));
  assign in_digits = (k_q >= b3_q);
  assign fin       = (k_q + 1'b1 == emit_q);

  always_comb begin
    priority if (k_q < b1_q) begin
      char_c = job_q.sign_char;
    end else if (k_q < b2_q) begin
      if (k_q == b1_q) begin
        char_c = ira_pkg::ChZero;
      end else begin
        char_c = job_q.upper ? ira_pkg::ChUpperX : ira_pkg::ChLowerX;
      end
    end else if (k_q < b3_q) begin
      char_c = ira_pkg::ChZero;
    end else begin
      char_c = ira_pkg::digit_char(rd_q, job_q.upper);
    end
  end

  always_comb begin
    unique case (state_q)
      ST_LEN:  dp_d = count_q[AddrW-1:0] - 1'b1;
      ST_EMIT: dp_d = (out_free && in_digits) ? dp_q - 1'b1 : dp_q;
      default: dp_d = dp_q;
    endcase
  end

  // digit store, read one entry ahead of the output
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[count_q[AddrW-1:0]] <= rem_c;
    end
    rd_q <= store_q[dp_d];
  end

  assign pop_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      step_q   <= '0;
      count_q  <= '0;
      k_q      <= '0;
      dp_q     <= '0;
    end else begin
      dp_q <= dp_d;
      if (load_out) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            job_q   <= pop_job_i;
            dq_q    <= pop_job_i.mag;
            rem_q   <= '0;
            step_q  <= '0;
            count_q <= '0;
            state_q <= pop_job_i.bad ? ST_ERR : ST_DIV;
          end
        end
        ST_DIV: begin
          dq_q   <= quo_c;
          rem_q  <= wr_en ? '0 : rem_c;
          step_q <= step_q + 1'b1;
          if (wr_en) begin
            count_q <= count_q + 1'b1;
            if (quo_c == '0 || count_q == LenW'(ira_pkg::DigitStoreDepth - 1)) begin
              state_q <= ST_LEN;
            end
          end
        end
        ST_LEN: begin
          b1_q    <= b1_d;
          b2_q    <= b2_d;
          b3_q    <= b3_d;
          len_q   <= len_d;
          emit_q  <= (len_d < Limit) ? len_d : Limit;
          k_q     <= '0;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            ochar_q  <= char_c;
            olast_q  <= fin;
            otrunc_q <= fin && (len_q > Limit);
            olen_q   <= fin ? len_q : '0;
            obad_q   <= 1'b0;
            k_q      <= k_q + 1'b1;
            if (fin) begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            ochar_q  <= ira_pkg::ChNul;
            olast_q  <= 1'b1;
            otrunc_q <= 1'b0;
            olen_q   <= '0;
            obad_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.character    = ochar_q;
  assign out_o.last         = olast_q;
  assign out_o.truncated    = otrunc_q;
  assign out_o.total_length = olen_q;
  assign out_o.bad_radix    = obad_q;

endmodule

// ----- sv/integer_to_radix_ascii.sv -----
// top level: signed 64-bit integer to ascii text in radix 2 to 36
// flow: a word is taken from the queue, the division loop takes all 64 dividend bits
//   for each digit (8 quotient bits a cycle), the text is sized, then one character
//   a cycle goes out while the output is not stalled
// a bad radix skips division and sizing; the two-entry queue takes words while the back end works
// reset: radix 10, flags 0, queue and output empty; the digit store is not cleared
module integer_to_radix_ascii #(
  parameter int OUTPUT_LIMIT = ira_pkg::OutputLimit
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ira_in_if.sink     in_i,
  ira_cfg_if.sink    cfg_i,
  ira_out_if.source  out_o
);

  logic          push_valid;
  logic          push_ready;
  ira_pkg::job_t push_job;
  logic          pop_valid;
  logic          pop_ready;
  ira_pkg::job_t pop_job;

  ira_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  ira_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  ira_back #(
    .OUTPUT_LIMIT (OUTPUT_LIMIT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_o       (out_o)
  );

endmodule
